// ----- sv/ascon_pkg.sv -----
// Shared types, codes and helper functions for the Ascon-128 AEAD engine.
// Used by the channel interfaces, the round unit and the top level.
package ascon_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned WORDS   = 5;
    localparam int unsigned RND_W   = 4;
    localparam int unsigned BCNT_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] ASCON_IV = 64'h80400c0600000000;

    localparam logic [RND_W-1:0] RND_FIRST_P12 = 4'd0;
    localparam logic [RND_W-1:0] RND_FIRST_P6  = 4'd6;
    localparam logic [RND_W-1:0] RND_LAST      = 4'd11;

    localparam logic [BCNT_W-1:0] FULL_BLOCK = 4'd8;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_state;

    typedef enum logic [2:0] {
        ACT_INIT     = 3'd0,
        ACT_ABSORB   = 3'd1,
        ACT_END_AD   = 3'd2,
        ACT_ENCRYPT  = 3'd3,
        ACT_DECRYPT  = 3'd4,
        ACT_FINALIZE = 3'd5
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_reg;

    // Round constant: high nibble is 15 minus the round index, low nibble the index.
    function automatic logic [7:0] round_const(input logic [RND_W-1:0] rnd);
        return {~rnd, rnd};
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

// ----- sv/ascon_in_if.sv -----
// Input channel of the Ascon engine: valid/ready handshake and one item.
// Depends on ascon_pkg for field widths.
interface ascon_in_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       action;
    logic [ascon_pkg::WORD_W-1:0]     data_in;
    logic [ascon_pkg::BCNT_W-1:0]     byte_count;
    logic [ascon_pkg::WORD_W-1:0]     nonce_high;
    logic [ascon_pkg::WORD_W-1:0]     nonce_low;
    logic [ascon_pkg::WORD_W-1:0]     expected_tag_high;
    logic [ascon_pkg::WORD_W-1:0]     expected_tag_low;

    modport source (
        output valid, action, data_in, byte_count, nonce_high, nonce_low,
               expected_tag_high, expected_tag_low,
        input  ready
    );

    modport sink (
        input  valid, action, data_in, byte_count, nonce_high, nonce_low,
               expected_tag_high, expected_tag_low,
        output ready
    );
endinterface

// ----- sv/ascon_out_if.sv -----
// Result channel of the Ascon engine: valid/ready handshake and one item.
// Depends on ascon_pkg for field widths.
interface ascon_out_if;
    logic                             valid;
    logic                             ready;
    logic [ascon_pkg::WORD_W-1:0]     data_out;
    logic [ascon_pkg::WORD_W-1:0]     tag_high;
    logic [ascon_pkg::WORD_W-1:0]     tag_low;
    logic                             tag_match;

    modport source (
        output valid, data_out, tag_high, tag_low, tag_match,
        input  ready
    );

    modport sink (
        input  valid, data_out, tag_high, tag_low, tag_match,
        output ready
    );
endinterface

// ----- sv/ascon_round.sv -----
// One Ascon permutation round: constant addition, S-box layer, linear layer.
// Depends on ascon_pkg for the state type, round constant and rotation.
module ascon_round (
    input  ascon_pkg::t_state                 i_x,
    input  logic [ascon_pkg::RND_W-1:0]       i_rnd,
    output ascon_pkg::t_state                 o_x
);

    ascon_pkg::t_state w_a;
    ascon_pkg::t_state w_t;
    ascon_pkg::t_state w_b;
    ascon_pkg::t_state w_c;

    always_comb begin
        // Constant addition and the input half of the S-box.
        w_a    = i_x;
        w_a[2] = i_x[2] ^ {56'd0, ascon_pkg::round_const(i_rnd)};
        w_a[0] = w_a[0] ^ w_a[4];
        w_a[4] = w_a[4] ^ w_a[3];
        w_a[2] = w_a[2] ^ w_a[1];

        for (int i = 0; i < 5; i++) begin
            w_t[i] = ~w_a[i] & w_a[(i + 1) % 5];
        end
        for (int i = 0; i < 5; i++) begin
            w_b[i] = w_a[i] ^ w_t[(i + 1) % 5];
        end

        // Output half of the S-box.
        w_c    = w_b;
        w_c[1] = w_b[1] ^ w_b[0];
        w_c[0] = w_b[0] ^ w_b[4];
        w_c[3] = w_b[3] ^ w_b[2];
        w_c[2] = ~w_b[2];

        o_x[0] = w_c[0] ^ ascon_pkg::rotr(w_c[0], 19) ^ ascon_pkg::rotr(w_c[0], 28);
        o_x[1] = w_c[1] ^ ascon_pkg::rotr(w_c[1], 61) ^ ascon_pkg::rotr(w_c[1], 39);
        o_x[2] = w_c[2] ^ ascon_pkg::rotr(w_c[2], 1)  ^ ascon_pkg::rotr(w_c[2], 6);
        o_x[3] = w_c[3] ^ ascon_pkg::rotr(w_c[3], 10) ^ ascon_pkg::rotr(w_c[3], 17);
        o_x[4] = w_c[4] ^ ascon_pkg::rotr(w_c[4], 7)  ^ ascon_pkg::rotr(w_c[4], 41);
    end

endmodule

// ----- sv/ascon_aead_engine.sv -----
// Ascon-128 AEAD engine top level: sequencer, state, key registers, result register.
// Sequence from accept to result valid: a full AD, encrypt or decrypt block runs six
// rounds through the single round unit, then the result stage; init and finalize run
// twelve rounds, then the result stage; end-of-AD and padded last message blocks go straight to it.
// One item is in work at a time; a new item is taken only once the last has left the result stage.
// Synchronous active-low reset clears the permutation state, key and handshakes.
module ascon_aead_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ascon_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ascon_pkg::WORD_W-1:0]        i_cfg_data,
    ascon_in_if.sink                            i_in_ch,
    ascon_out_if.source                         o_out_ch
);

    // Sequencer states. IDLE takes an item and applies everything that happens
    // before the permutation; ROUND runs one round per cycle through the shared
    // round unit; EMIT applies the post-permutation step and loads the result.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_EMIT  = 3'b100
    } t_seq_state;

    t_seq_state                        r_state, n_state;
    ascon_pkg::t_state                 r_x, n_x;
    logic [ascon_pkg::RND_W-1:0]       r_rnd, n_rnd;
    ascon_pkg::t_action                r_act, n_act;
    logic [ascon_pkg::WORD_W-1:0]      r_dout, n_dout;
    logic [ascon_pkg::WORD_W-1:0]      r_exp_hi, n_exp_hi;
    logic [ascon_pkg::WORD_W-1:0]      r_exp_lo, n_exp_lo;
    logic [ascon_pkg::WORD_W-1:0]      r_key_hi, r_key_lo;

    logic                              r_out_valid, n_out_valid;
    logic [ascon_pkg::WORD_W-1:0]      r_out_dout, n_out_dout;
    logic [ascon_pkg::WORD_W-1:0]      r_out_tag_hi, n_out_tag_hi;
    logic [ascon_pkg::WORD_W-1:0]      r_out_tag_lo, n_out_tag_lo;
    logic                              r_out_match, n_out_match;

    ascon_pkg::t_state                 w_round_x;
    logic                              w_accept;
    logic                              w_emit;
    logic [ascon_pkg::BCNT_W-1:0]      w_n;
    logic                              w_full;
    logic [ascon_pkg::WORD_W-1:0]      w_mask;
    logic [ascon_pkg::WORD_W-1:0]      w_pad;
    logic [ascon_pkg::WORD_W-1:0]      w_data;
    logic [ascon_pkg::WORD_W-1:0]      w_tag_hi;
    logic [ascon_pkg::WORD_W-1:0]      w_tag_lo;

    ascon_round u_round (
        .i_x   (r_x),
        .i_rnd (r_rnd),
        .o_x   (w_round_x)
    );

    // The input side is open only while no item is in work. The result
    // register decouples the two sides, so a waiting result does not block it.
    assign i_in_ch.ready = (r_state == ST_IDLE);
    assign w_accept      = i_in_ch.valid && (r_state == ST_IDLE);
    assign w_emit        = (r_state == ST_EMIT) && (!r_out_valid || o_out_ch.ready);

    // Byte counts above eight count as a full block. The mask keeps the
    // leading valid bytes, and the pad byte sits right after them.
    assign w_n    = (i_in_ch.byte_count > ascon_pkg::FULL_BLOCK) ? ascon_pkg::FULL_BLOCK
                                                                 : i_in_ch.byte_count;
    assign w_full = (w_n == ascon_pkg::FULL_BLOCK);
    assign w_mask = w_full ? {ascon_pkg::WORD_W{1'b1}}
                           : ~({ascon_pkg::WORD_W{1'b1}} >> {w_n[2:0], 3'b000});
    assign w_pad  = w_full ? '0 : (64'h8000_0000_0000_0000 >> {w_n[2:0], 3'b000});
    assign w_data = i_in_ch.data_in & w_mask;

    assign w_tag_hi = r_x[3] ^ r_key_hi;
    assign w_tag_lo = r_x[4] ^ r_key_lo;

    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_rnd        = r_rnd;
        n_act        = r_act;
        n_dout       = r_dout;
        n_exp_hi     = r_exp_hi;
        n_exp_lo     = r_exp_lo;
        n_out_valid  = r_out_valid && !o_out_ch.ready;
        n_out_dout   = r_out_dout;
        n_out_tag_hi = r_out_tag_hi;
        n_out_tag_lo = r_out_tag_lo;
        n_out_match  = r_out_match;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_act    = ascon_pkg::t_action'(i_in_ch.action);
                    n_dout   = '0;
                    n_exp_hi = i_in_ch.expected_tag_high;
                    n_exp_lo = i_in_ch.expected_tag_low;
                    n_state  = ST_EMIT;
                    unique case (i_in_ch.action)
                        ascon_pkg::ACT_INIT: begin
                            n_x     = {i_in_ch.nonce_low, i_in_ch.nonce_high,
                                       r_key_lo, r_key_hi, ascon_pkg::ASCON_IV};
                            n_rnd   = ascon_pkg::RND_FIRST_P12;
                            n_state = ST_ROUND;
                        end
                        ascon_pkg::ACT_ABSORB: begin
                            // A short AD block is padded and still permuted.
                            n_x[0]  = r_x[0] ^ w_data ^ w_pad;
                            n_rnd   = ascon_pkg::RND_FIRST_P6;
                            n_state = ST_ROUND;
                        end
                        ascon_pkg::ACT_END_AD: begin
                            n_x[4] = r_x[4] ^ 64'd1;
                        end
                        ascon_pkg::ACT_ENCRYPT: begin
                            n_dout = (r_x[0] ^ w_data) & w_mask;
                            n_x[0] = r_x[0] ^ w_data ^ w_pad;
                            if (w_full) begin
                                n_rnd   = ascon_pkg::RND_FIRST_P6;
                                n_state = ST_ROUND;
                            end
                        end
                        ascon_pkg::ACT_DECRYPT: begin
                            // The ciphertext replaces the leading bytes of the rate
                            // word; trailing state bytes stay, then the pad goes in.
                            n_dout = (r_x[0] ^ w_data) & w_mask;
                            n_x[0] = (w_data | (r_x[0] & ~w_mask)) ^ w_pad;
                            if (w_full) begin
                                n_rnd   = ascon_pkg::RND_FIRST_P6;
                                n_state = ST_ROUND;
                            end
                        end
                        ascon_pkg::ACT_FINALIZE: begin
                            n_x[1]  = r_x[1] ^ r_key_hi;
                            n_x[2]  = r_x[2] ^ r_key_lo;
                            n_rnd   = ascon_pkg::RND_FIRST_P12;
                            n_state = ST_ROUND;
                        end
                        default: begin
                            // Unknown actions leave the state alone and give zeros.
                        end
                    endcase
                end
            end
            ST_ROUND: begin
                n_x   = w_round_x;
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == ascon_pkg::RND_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_dout   = r_dout;
                    n_out_tag_hi = '0;
                    n_out_tag_lo = '0;
                    n_out_match  = 1'b0;
                    if (r_act == ascon_pkg::ACT_INIT) begin
                        n_x[3] = r_x[3] ^ r_key_hi;
                        n_x[4] = r_x[4] ^ r_key_lo;
                    end
                    if (r_act == ascon_pkg::ACT_FINALIZE) begin
                        n_out_tag_hi = w_tag_hi;
                        n_out_tag_lo = w_tag_lo;
                        n_out_match  = (w_tag_hi == r_exp_hi) && (w_tag_lo == r_exp_lo);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_x         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_out_valid <= n_out_valid;
        end
    end

    // Key registers; the user must write them only while the engine is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (ascon_pkg::t_cfg_reg'(i_cfg_idx))
                ascon_pkg::CFG_KEY_HIGH: r_key_hi <= i_cfg_data;
                ascon_pkg::CFG_KEY_LOW:  r_key_lo <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd        <= n_rnd;
        r_act        <= n_act;
        r_dout       <= n_dout;
        r_exp_hi     <= n_exp_hi;
        r_exp_lo     <= n_exp_lo;
        r_out_dout   <= n_out_dout;
        r_out_tag_hi <= n_out_tag_hi;
        r_out_tag_lo <= n_out_tag_lo;
        r_out_match  <= n_out_match;
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.data_out  = r_out_dout;
    assign o_out_ch.tag_high  = r_out_tag_hi;
    assign o_out_ch.tag_low   = r_out_tag_lo;
    assign o_out_ch.tag_match = r_out_match;

    // Init and finalize always go through the round unit.
    a_perm_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_ch.action == ascon_pkg::ACT_INIT ||
                      i_in_ch.action == ascon_pkg::ACT_FINALIZE))
        |=> (r_state == ST_ROUND))
        else $error("permuting action did not start the round sequence");

    // The last round hands over to the result stage.
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == ascon_pkg::RND_LAST) |=> (r_state == ST_EMIT))
        else $error("round sequence overran its last round");

    // A new result appears only out of the result stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("result register loaded outside the result stage");

    // The round counter stays inside the twelve-round schedule while running.
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_rnd <= ascon_pkg::RND_LAST))
        else $error("round index out of range");

endmodule

// ----- tb/sv/ascon_aead_checker.sv -----
`timescale 1ns / 1ps
// Self-checking monitor for the Ascon-128 AEAD engine: mirrors the key registers and
// the 320-bit sponge, predicts each result block and compares it with the engine's.
// Depends on ascon_pkg and the ascon_in_if / ascon_out_if channel interfaces.
module ascon_aead_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ascon_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ascon_pkg::WORD_W-1:0]    i_cfg_data,
    ascon_in_if                             i_in_ch,
    ascon_out_if                            i_out_ch,
    output int                              o_mismatch_count,
    output int                              o_blocks_in_flight
);
    import ascon_pkg::*;

    localparam int unsigned ROUNDS_FULL = 12;
    localparam int unsigned ROUNDS_DATA = 6;
    localparam int          MAX_REPORTS = 10;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] tag_high;
        logic [WORD_W-1:0] tag_low;
        logic              tag_match;
    } block_result_t;

    t_state            sponge = '0;
    logic [WORD_W-1:0] key_hi = '0;
    logic [WORD_W-1:0] key_lo = '0;
    block_result_t     predicted_blocks_q[$];
    int                mismatches = 0;

    function automatic logic [WORD_W-1:0] ror64(input logic [WORD_W-1:0] v,
                                                input int unsigned n);
        logic [2*WORD_W-1:0] twice;
        twice = {v, v};
        return twice[n +: WORD_W];
    endfunction

    // The last `count` rounds of the Ascon permutation.
    function automatic t_state ascon_rounds(input t_state s, input int unsigned count);
        t_state            x;
        logic [WORD_W-1:0] t0, t1, t2, t3, t4;
        x = s;
        for (int unsigned r = ROUNDS_FULL - count; r < ROUNDS_FULL; r++) begin
            x[2] = x[2] ^ {56'd0, 4'(15 - r), 4'(r)};
            x[0] ^= x[4];
            x[4] ^= x[3];
            x[2] ^= x[1];
            t0 = ~x[0] & x[1];
            t1 = ~x[1] & x[2];
            t2 = ~x[2] & x[3];
            t3 = ~x[3] & x[4];
            t4 = ~x[4] & x[0];
            x[0] ^= t1;
            x[1] ^= t2;
            x[2] ^= t3;
            x[3] ^= t4;
            x[4] ^= t0;
            x[1] ^= x[0];
            x[0] ^= x[4];
            x[3] ^= x[2];
            x[2] = ~x[2];
            x[0] ^= ror64(x[0], 19) ^ ror64(x[0], 28);
            x[1] ^= ror64(x[1], 61) ^ ror64(x[1], 39);
            x[2] ^= ror64(x[2], 1) ^ ror64(x[2], 6);
            x[3] ^= ror64(x[3], 10) ^ ror64(x[3], 17);
            x[4] ^= ror64(x[4], 7) ^ ror64(x[4], 41);
        end
        return x;
    endfunction

    // Applies one item to the mirrored sponge and returns the block it must produce.
    function automatic block_result_t predict_block(input logic [2:0]        code,
                                                    input logic [WORD_W-1:0] din,
                                                    input logic [BCNT_W-1:0] cnt,
                                                    input logic [WORD_W-1:0] nonce_hi,
                                                    input logic [WORD_W-1:0] nonce_lo,
                                                    input logic [WORD_W-1:0] rx_tag_hi,
                                                    input logic [WORD_W-1:0] rx_tag_lo);
        int unsigned       nbytes;
        logic              full;
        logic [WORD_W-1:0] keep;
        logic [WORD_W-1:0] pad;
        logic [WORD_W-1:0] blk;
        block_result_t     res;
        nbytes = (cnt > FULL_BLOCK) ? 8 : cnt;
        full   = (nbytes == 8);
        keep   = (nbytes == 0) ? '0 : ({WORD_W{1'b1}} << (WORD_W - 8 * nbytes));
        pad    = full ? '0 : (64'h80 << (56 - 8 * nbytes));
        blk    = din & keep;
        res    = '0;
        case (t_action'(code))
            ACT_INIT: begin
                sponge = {nonce_lo, nonce_hi, key_lo, key_hi, ASCON_IV};
                sponge = ascon_rounds(sponge, ROUNDS_FULL);
                sponge[3] ^= key_hi;
                sponge[4] ^= key_lo;
            end
            ACT_ABSORB: begin
                // A short block is padded but still permuted.
                sponge[0] ^= blk ^ pad;
                sponge = ascon_rounds(sponge, ROUNDS_DATA);
            end
            ACT_END_AD: begin
                sponge[4] ^= 64'd1;
            end
            ACT_ENCRYPT: begin
                sponge[0] ^= blk;
                res.data = sponge[0] & keep;
                if (full) sponge = ascon_rounds(sponge, ROUNDS_DATA);
                else sponge[0] ^= pad;
            end
            ACT_DECRYPT: begin
                res.data = (sponge[0] ^ blk) & keep;
                if (full) begin
                    sponge[0] = blk;
                    sponge = ascon_rounds(sponge, ROUNDS_DATA);
                end else begin
                    sponge[0] = blk | (sponge[0] & ~keep);
                    sponge[0] ^= pad;
                end
            end
            ACT_FINALIZE: begin
                sponge[1] ^= key_hi;
                sponge[2] ^= key_lo;
                sponge = ascon_rounds(sponge, ROUNDS_FULL);
                res.tag_high  = sponge[3] ^ key_hi;
                res.tag_low   = sponge[4] ^ key_lo;
                res.tag_match = (res.tag_high == rx_tag_hi) && (res.tag_low == rx_tag_lo);
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        block_result_t want;
        if (!i_rst_n) begin
            sponge = '0;
            key_hi = '0;
            key_lo = '0;
            predicted_blocks_q.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready)
                predicted_blocks_q.push_back(predict_block(i_in_ch.action, i_in_ch.data_in,
                    i_in_ch.byte_count, i_in_ch.nonce_high, i_in_ch.nonce_low,
                    i_in_ch.expected_tag_high, i_in_ch.expected_tag_low));
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (predicted_blocks_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result block with no item outstanding", $time);
                end else begin
                    want = predicted_blocks_q.pop_front();
                    compare_field("data_out", want.data, i_out_ch.data_out);
                    compare_field("tag_high", want.tag_high, i_out_ch.tag_high);
                    compare_field("tag_low", want.tag_low, i_out_ch.tag_low);
                    compare_field("tag_match", {63'd0, want.tag_match},
                                  {63'd0, i_out_ch.tag_match});
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_KEY_HIGH: key_hi = i_cfg_data;
                    CFG_KEY_LOW:  key_lo = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_mismatch_count   <= mismatches;
        o_blocks_in_flight <= predicted_blocks_q.size();
    end

endmodule

// ----- tb/sv/tb_ascon_aead_engine.sv -----
`timescale 1ns / 1ps
// Top of the Ascon-128 AEAD engine testbench: clock, reset, key writes, item stimulus
// and result back-pressure; the checker beside the engine does all prediction.
// Depends on ascon_pkg, the channel interfaces, ascon_aead_engine and ascon_aead_checker.
module tb_ascon_aead_engine;
    import ascon_pkg::*;

    // Action codes outside the defined set; the engine must leave its state alone.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int PHASES             = 7;
    localparam int SESSIONS_PER_PHASE = 8;
    localparam int NOISE_PER_SESSION  = 3;
    localparam int HOLD_PHASE         = 3;
    localparam int LONG_HOLD_CYCLES   = 300;
    // The longest sequence is twelve rounds plus the result stage; leave a little margin on top.
    localparam int SETTLE_CYCLES      = 16;

    typedef enum {RX_ALWAYS, RX_COIN, RX_THREE_OF_FOUR, RX_SPARSE} rx_pattern_t;

    typedef struct packed {
        logic [2:0]        act;
        logic [WORD_W-1:0] data;
        logic [BCNT_W-1:0] cnt;
        logic [WORD_W-1:0] nonce_hi;
        logic [WORD_W-1:0] nonce_lo;
        logic [WORD_W-1:0] tag_hi;
        logic [WORD_W-1:0] tag_lo;
    } block_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] tag_hi;
        logic [WORD_W-1:0] tag_lo;
    } returned_block_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0]    cfg_data;
    int                   mismatch_count;
    int                   blocks_in_flight;

    // Every block the engine hands back, in order; cleared before each encrypt session
    // so that the matching decrypt session can replay its ciphertext and tag.
    returned_block_t returned_q[$];

    // Sender burst bookkeeping, and the request for one long receiver hold-off.
    int burst_left = 0;
    bit hold_ask   = 1'b0;

    ascon_in_if  in_ch ();
    ascon_out_if out_ch ();

    ascon_aead_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    ascon_aead_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_data         (cfg_data),
        .i_in_ch            (in_ch),
        .i_out_ch           (out_ch),
        .o_mismatch_count   (mismatch_count),
        .o_blocks_in_flight (blocks_in_flight)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Builds an item; the nonce and tag fields get random values unless overridden.
    function automatic block_item_t make_item(input logic [2:0] act,
                                              input logic [BCNT_W-1:0] cnt,
                                              input logic [WORD_W-1:0] data);
        block_item_t it;
        it.act      = act;
        it.cnt      = cnt;
        it.data     = data;
        it.nonce_hi = rand64();
        it.nonce_lo = rand64();
        it.tag_hi   = rand64();
        it.tag_lo   = rand64();
        return it;
    endfunction

    // Presents one item and returns at the clock edge where it is taken. Valid stays
    // high afterwards, so back-to-back items in a burst never drop it; when a burst
    // runs out the sender drops valid and idles before starting the next one.
    task automatic offer(input block_item_t it);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            // One burst in four is long, which gives stretches with no sender gaps.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid             <= 1'b1;
        in_ch.action            <= it.act;
        in_ch.data_in           <= it.data;
        in_ch.byte_count        <= it.cnt;
        in_ch.nonce_high        <= it.nonce_hi;
        in_ch.nonce_low         <= it.nonce_lo;
        in_ch.expected_tag_high <= it.tag_hi;
        in_ch.expected_tag_low  <= it.tag_lo;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stops offering and waits until every outstanding block has come back, then
    // lets the engine run quiet for a full worst-case latency.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (blocks_in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Loads both key halves on consecutive cycles; only called while the engine is idle.
    task automatic write_keys(input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_KEY_HIGH;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_idx  <= CFG_KEY_LOW;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // One well-formed encryption of random AD and plaintext, then the decryption of
    // the ciphertext it produced under the same nonce. The decrypt finalize presents
    // the tag from the encrypt side, so the tag should match unless it is forged.
    task automatic run_session_pair(input bit forge_tag);
        block_item_t       it;
        logic [WORD_W-1:0] nonce_hi;
        logic [WORD_W-1:0] nonce_lo;
        logic [WORD_W-1:0] ad_blk[$];
        logic [BCNT_W-1:0] ad_cnt[$];
        logic [BCNT_W-1:0] msg_cnt[$];
        returned_block_t   tag_blk;
        logic [WORD_W-1:0] ct;
        int                n_ad;
        int                n_msg;
        nonce_hi = rand64();
        nonce_lo = rand64();
        n_ad     = $urandom_range(0, 3);
        n_msg    = $urandom_range(0, 4);
        // Only the last AD or message block may be short; half the time it is.
        for (int i = 0; i < n_ad; i++) begin
            ad_blk.push_back(rand64());
            ad_cnt.push_back((i == n_ad - 1 && $urandom_range(0, 1) == 1)
                             ? BCNT_W'($urandom_range(0, 7)) : FULL_BLOCK);
        end
        for (int i = 0; i < n_msg; i++)
            msg_cnt.push_back((i == n_msg - 1 && $urandom_range(0, 1) == 1)
                              ? BCNT_W'($urandom_range(0, 7)) : FULL_BLOCK);

        settle();
        returned_q.delete();

        it = make_item(ACT_INIT, FULL_BLOCK, rand64());
        it.nonce_hi = nonce_hi;
        it.nonce_lo = nonce_lo;
        offer(it);
        for (int i = 0; i < n_ad; i++) offer(make_item(ACT_ABSORB, ad_cnt[i], ad_blk[i]));
        offer(make_item(ACT_END_AD, FULL_BLOCK, rand64()));
        for (int i = 0; i < n_msg; i++) offer(make_item(ACT_ENCRYPT, msg_cnt[i], rand64()));
        offer(make_item(ACT_FINALIZE, FULL_BLOCK, rand64()));

        // The ciphertext and tag are needed before the decrypt side can start.
        settle();
        tag_blk = returned_q[returned_q.size() - 1];

        it = make_item(ACT_INIT, FULL_BLOCK, rand64());
        it.nonce_hi = nonce_hi;
        it.nonce_lo = nonce_lo;
        offer(it);
        for (int i = 0; i < n_ad; i++) offer(make_item(ACT_ABSORB, ad_cnt[i], ad_blk[i]));
        offer(make_item(ACT_END_AD, FULL_BLOCK, rand64()));
        for (int i = 0; i < n_msg; i++) begin
            // Results 0..n_ad+1 are init, AD and end of AD; the ciphertext follows.
            // Bytes past the count are filled with junk, which the engine must ignore.
            ct = returned_q[n_ad + 2 + i].data ^ (rand64() >> (8 * msg_cnt[i]));
            offer(make_item(ACT_DECRYPT, msg_cnt[i], ct));
        end
        it = make_item(ACT_FINALIZE, FULL_BLOCK, rand64());
        it.tag_hi = tag_blk.tag_hi;
        it.tag_lo = tag_blk.tag_lo;
        if (forge_tag) begin
            if ($urandom_range(0, 1) == 1) it.tag_hi[$urandom_range(0, 63)] ^= 1'b1;
            else it.tag_lo[$urandom_range(0, 63)] ^= 1'b1;
        end
        offer(it);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            returned_q.push_back({out_ch.data_out, out_ch.tag_high, out_ch.tag_low});
    end

    // Result back-pressure: a random pattern per stretch of cycles, and one long
    // hold-off on request while the sender keeps offering, so the engine backs up.
    initial begin : receiver
        rx_pattern_t pattern;
        int          stretch;
        int          hold_left;
        int          tick;
        logic        rdy;
        hold_left = 0;
        tick      = 0;
        forever begin
            pattern = rx_pattern_t'($urandom_range(0, 3));
            stretch = $urandom_range(16, 96);
            repeat (stretch) begin
                if (hold_ask) begin
                    hold_ask  = 1'b0;
                    hold_left = LONG_HOLD_CYCLES;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    rdy = 1'b0;
                end else begin
                    case (pattern)
                        RX_ALWAYS:        rdy = 1'b1;
                        RX_COIN:          rdy = ($urandom_range(0, 1) == 1);
                        RX_THREE_OF_FOUR: rdy = (tick % 4 != 3);
                        default:          rdy = ($urandom_range(0, 3) == 0);
                    endcase
                end
                out_ch.ready <= rdy;
                tick++;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        block_item_t       it;
        logic [WORD_W-1:0] key_hi;
        logic [WORD_W-1:0] key_lo;

        i_rst_n                 <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= CFG_KEY_HIGH;
        cfg_data                <= '0;
        in_ch.valid             <= 1'b0;
        in_ch.action            <= ACT_INIT;
        in_ch.data_in           <= '0;
        in_ch.byte_count        <= '0;
        in_ch.nonce_high        <= '0;
        in_ch.nonce_low         <= '0;
        in_ch.expected_tag_high <= '0;
        in_ch.expected_tag_low  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extreme keys, nonces, data and tags, every action, short and
        // empty blocks, byte counts above eight, and the two undefined action codes.
        write_keys('0, '1);
        it = make_item(ACT_INIT, FULL_BLOCK, rand64());
        it.nonce_hi = '0;
        it.nonce_lo = '0;
        offer(it);
        it.nonce_hi = '1;
        it.nonce_lo = '1;
        offer(it);
        offer(make_item(ACT_ABSORB, FULL_BLOCK, '1));
        offer(make_item(ACT_ABSORB, 4'd0, '1));
        offer(make_item(ACT_ABSORB, 4'd3, rand64()));
        offer(make_item(ACT_ABSORB, 4'd9, rand64()));
        offer(make_item(ACT_ABSORB, 4'd15, '1));
        offer(make_item(ACT_END_AD, 4'd5, rand64()));
        offer(make_item(ACT_ENCRYPT, FULL_BLOCK, '0));
        offer(make_item(ACT_ENCRYPT, FULL_BLOCK, '1));
        offer(make_item(ACT_ENCRYPT, 4'd1, '1));
        offer(make_item(ACT_ENCRYPT, 4'd0, rand64()));
        offer(make_item(ACT_DECRYPT, FULL_BLOCK, '1));
        offer(make_item(ACT_DECRYPT, 4'd7, rand64()));
        offer(make_item(ACT_DECRYPT, 4'd0, '1));
        offer(make_item(ACT_DECRYPT, 4'd12, rand64()));
        it = make_item(ACT_FINALIZE, FULL_BLOCK, rand64());
        it.tag_hi = '0;
        it.tag_lo = '0;
        offer(it);
        it.tag_hi = '1;
        it.tag_lo = '1;
        offer(it);
        offer(make_item(ACT_SPARE_6, FULL_BLOCK, rand64()));
        offer(make_item(ACT_SPARE_7, 4'd15, '1));
        // Empty AD: end of AD straight after init, then an empty last message block.
        offer(make_item(ACT_INIT, FULL_BLOCK, rand64()));
        offer(make_item(ACT_END_AD, FULL_BLOCK, '0));
        offer(make_item(ACT_ENCRYPT, 4'd0, '0));
        offer(make_item(ACT_FINALIZE, FULL_BLOCK, rand64()));

        // Random part: each phase runs under its own key, extremes first. Most items
        // come from matched encrypt/decrypt sessions; the rest are random actions
        // with random byte counts that break the usual order.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0:       begin key_hi = '1;       key_lo = '1;       end
                1:       begin key_hi = '1;       key_lo = '0;       end
                2:       begin key_hi = '0;       key_lo = rand64(); end
                default: begin key_hi = rand64(); key_lo = rand64(); end
            endcase
            write_keys(key_hi, key_lo);
            for (int s = 0; s < SESSIONS_PER_PHASE; s++) begin
                if (p == HOLD_PHASE && s == 0) hold_ask = 1'b1;
                run_session_pair($urandom_range(0, 3) == 0);
                for (int k = 0; k < NOISE_PER_SESSION; k++)
                    offer(make_item(3'($urandom_range(0, 7)), BCNT_W'($urandom_range(0, 15)),
                                    rand64()));
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
